// File: rtl/rsch_pkg.sv
// Shared types, constants and the sine table for the ray segment closest hit block.
// Used by every module under rtl; depends on nothing else.
package rsch_pkg;

    localparam int MAX_WALLS      = 32;
    localparam int WALL_IDX_W     = 5;
    localparam int WALL_CNT_W     = 6;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 1;
    localparam int SC_W           = TRIG_W + 1;
    localparam int RV_W           = 27;
    localparam int NUM_W          = 35;
    localparam int DEN_W          = 24;
    localparam int DIV_CNT_W      = $clog2(NUM_W + 1);
    localparam int SQ_W           = 22;
    localparam int SQ_R           = SQ_W / 2;
    localparam int SQ_CNT_W       = $clog2(SQ_R + 1);
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);

    localparam logic [2:0] CFG_WALL_COUNT    = 3'd0;
    localparam logic [2:0] CFG_VIEW_RANGE    = 3'd1;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_BAR_WIDTH     = 3'd3;
    localparam logic [2:0] CFG_BAR_ORIGIN    = 3'd4;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_CAST = 1'b1;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] SERIES_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

    typedef logic [TRIG_W-1:0] sin_tab_t [0:90];

    typedef struct packed {
        logic                    mode;
        logic [WALL_IDX_W-1:0]   wall_index;
        logic [39:0]             wall;
        logic [9:0]              px;
        logic [9:0]              py;
        logic signed [SC_W-1:0]  sn;
        logic signed [SC_W-1:0]  cs;
        logic [5:0]              column;
    } cmd_t;

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t           t;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        s;
        for (int k = 0; k <= 90; k++) begin
            x = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
            x2 = (x * x) >> 30;
            term = x;
            sum = $signed(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / SERIES_DIV[n-1];
                if (n % 2 == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            s = ($unsigned(sum) + (64'd1 << (30 - TRIG_FRAC_BITS - 1))) >> (30 - TRIG_FRAC_BITS);
            if (s > (64'd1 << TRIG_FRAC_BITS)) begin
                s = 64'd1 << TRIG_FRAC_BITS;
            end
            t[k] = s[TRIG_W-1:0];
        end
        return t;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// File: rtl/ray_segment_closest_hit.sv
// Top level of the ray segment closest hit block: front end, command queue, back end.
// Depends on rsch_pkg, rsch_front, rsch_fifo and rsch_core.
//
// Input requests arrive on s_t*: s_tuser selects a wall load (0) or a ray cast (1).
// A load writes one wall table slot and gives no result. A cast gives one result on
// m_t*, with the hit flag on m_tuser. Results come out in request order.
// The front end decodes each request and looks up sine and cosine combinationally, then
// queues it (four entries); s_tready drops only while the queue is full.
// The back end takes one request at a time. A load only writes the wall table. A cast runs
// ray setup, then per wall in use a fetch and determinant step; a parallel wall ends there,
// a crossing goes on to the two 35-step dividers that run side by side and the box check,
// and a crossing inside both boxes also to the 11-step square root unit and the distance
// compare. Last, the output register loads.
// When m_tready is low the finished result holds in the output register; the back end
// then holds its next result in the finish step while the front end keeps filling the queue.
// Reset (aresetn low, synchronous) empties the queue, drops m_tvalid and restores
// the register defaults; the wall table keeps no defined contents until loaded.
// cfg_wr_en writes cfg_data to register cfg_index in the same cycle.
module ray_segment_closest_hit import rsch_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // wall_index, wall_ax, wall_ay, wall_bx, wall_by, player_x, player_y, ray_angle, column
    input  logic [79:0] s_tdata,
    // mode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit_x, hit_y, distance, bar_x, bar_top, bar_height, brightness, column_out
    output logic [79:0] m_tdata,
    // hit
    output logic        m_tuser
);
    cmd_t front_cmd;
    cmd_t fifo_dout;
    logic push;
    logic fifo_full;
    logic fifo_empty;
    logic fifo_pop;

    rsch_front u_front (
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .fifo_full(fifo_full), .push(push), .cmd(front_cmd)
    );

    rsch_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(push), .din(front_cmd), .full(fifo_full),
        .pop(fifo_pop), .dout(fifo_dout), .empty(fifo_empty)
    );

    rsch_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fifo_empty(fifo_empty), .fifo_dout(fifo_dout), .fifo_pop(fifo_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );
endmodule

// File: rtl/rsch_fifo.sv
// Command queue between the front end and the back end.
// Depends on rsch_pkg for cmd_t and the queue depth.
module rsch_fifo import rsch_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic empty
);
    cmd_t                  q_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   cnt_reg;

    assign full  = (cnt_reg == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            q_mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push && !full, pop && !empty})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end
endmodule

// File: rtl/rsch_front.sv
// Front end: decodes input requests, reduces the angle and looks up sine and cosine.
// Depends on rsch_pkg for cmd_t and the sine table.
module rsch_front import rsch_pkg::*; (
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        s_tuser,
    input  logic        fifo_full,
    output logic        push,
    output cmd_t        cmd
);
    logic [8:0]        ang_raw;
    logic [8:0]        ang;
    logic [1:0]        quad;
    logic [6:0]        rem;
    logic [TRIG_W-1:0] t_r;
    logic [TRIG_W-1:0] t_c;
    logic signed [SC_W-1:0] pos_r;
    logic signed [SC_W-1:0] pos_c;

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;

    always_comb begin
        ang_raw = s_tdata[73:65];
        ang = (ang_raw >= 9'd360) ? ang_raw - 9'd360 : ang_raw;
        if (ang < 9'd90) begin
            quad = 2'd0;
            rem  = ang[6:0];
        end else if (ang < 9'd180) begin
            quad = 2'd1;
            rem  = 7'(ang - 9'd90);
        end else if (ang < 9'd270) begin
            quad = 2'd2;
            rem  = 7'(ang - 9'd180);
        end else begin
            quad = 2'd3;
            rem  = 7'(ang - 9'd270);
        end
        t_r = SIN_TAB[rem];
        t_c = SIN_TAB[7'd90 - rem];
        pos_r = $signed({1'b0, t_r});
        pos_c = $signed({1'b0, t_c});

        cmd.mode       = s_tuser;
        cmd.wall_index = s_tdata[4:0];
        cmd.wall       = s_tdata[44:5];
        cmd.px         = s_tdata[54:45];
        cmd.py         = s_tdata[64:55];
        cmd.column     = s_tdata[79:74];
        case (quad)
            2'd0: begin
                cmd.sn = pos_r;
                cmd.cs = pos_c;
            end
            2'd1: begin
                cmd.sn = pos_c;
                cmd.cs = -pos_r;
            end
            2'd2: begin
                cmd.sn = -pos_r;
                cmd.cs = -pos_c;
            end
            default: begin
                cmd.sn = -pos_c;
                cmd.cs = pos_r;
            end
        endcase
    end
endmodule

// File: rtl/rsch_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rsch_pkg for the operand widths.
module rsch_div import rsch_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic                    busy,
    output logic signed [NUM_W-1:0] quo
);
    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     q_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic                 neg_reg;
    logic [DEN_W:0]       rem_sh;
    logic                 ge;

    assign busy   = busy_reg;
    assign quo    = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign rem_sh = {rem_reg, q_reg[NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            den_reg <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            neg_reg <= num[NUM_W-1] ^ den[DEN_W-1];
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end
endmodule

// File: rtl/rsch_sqrt.sv
// Iterative integer square root, one result bit per cycle, truncated.
// Depends on rsch_pkg for the operand widths.
module rsch_sqrt import rsch_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SQ_W-1:0]  rad,
    output logic             busy,
    output logic [SQ_R-1:0]  root
);
    logic                busy_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [SQ_W-1:0]     v_reg;
    logic [SQ_W-1:0]     r_reg;
    logic [SQ_W-1:0]     bit_reg;
    logic [SQ_W-1:0]     trial;

    assign busy  = busy_reg;
    assign root  = r_reg[SQ_R-1:0];
    assign trial = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= SQ_CNT_W'(SQ_R);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == SQ_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= rad;
            r_reg   <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end
endmodule

// File: rtl/rsch_core.sv
// Back end: wall table, configuration registers, intersection sequencer and result register.
// Depends on rsch_pkg, rsch_div and rsch_sqrt.
module rsch_core import rsch_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        fifo_empty,
    input  cmd_t        fifo_dout,
    output logic        fifo_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    output logic        m_tuser
);
    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_END   = 18'h00002,
        S_RAY   = 18'h00004,
        S_C1    = 18'h00008,
        S_FETCH = 18'h00010,
        S_PREP  = 18'h00020,
        S_C2    = 18'h00040,
        S_DET   = 18'h00080,
        S_NUMX  = 18'h00100,
        S_NUMY  = 18'h00200,
        S_DIVGO = 18'h00400,
        S_DIVW  = 18'h00800,
        S_BOX   = 18'h01000,
        S_SQ    = 18'h02000,
        S_SQGO  = 18'h04000,
        S_SQW   = 18'h08000,
        S_CMP   = 18'h10000,
        S_FIN   = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    logic [WALL_CNT_W-1:0] wall_count_reg;
    logic [9:0]            view_range_reg;
    logic [10:0]           screen_height_reg;
    logic [7:0]            bar_width_reg;
    logic [10:0]           bar_origin_reg;

    logic [39:0] wall_mem [MAX_WALLS];
    logic [39:0] rd_reg;

    cmd_t cmd_reg;
    logic signed [RV_W-2:0]  prodx_reg, prody_reg, prodx_next, prody_next;
    logic signed [11:0]      tx_reg, ty_reg, tx_next, ty_next;
    logic signed [12:0]      a1_reg, b1_reg, a1_next, b1_next;
    logic signed [22:0]      c1_reg, c1_next;
    logic [WALL_CNT_W-1:0]   widx_reg, widx_next;
    logic signed [11:0]      ax_reg, ay_reg, ex_reg, ey_reg;
    logic signed [10:0]      a2_reg, b2_reg;
    logic signed [21:0]      c2_reg, c2_next;
    logic signed [DEN_W-1:0] det_reg, det_next;
    logic signed [NUM_W-1:0] numx_reg, numy_reg, numx_next, numy_next;
    logic signed [11:0]      dx_reg, dy_reg;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [9:0]              best_reg, bx_reg, by_reg;
    logic                    hit_reg;

    logic                    m_valid_reg;
    logic [79:0]             m_data_reg;
    logic                    m_user_reg;

    logic signed [10:0]      px_s, py_s, rng_s;
    logic [WALL_CNT_W-1:0]   n_walls;
    logic                    last_wall;
    logic                    load_out;
    logic signed [NUM_W-1:0] qx, qy;
    logic                    divx_busy, divy_busy, div_go;
    logic                    sq_go, sq_busy;
    logic [SQ_R-1:0]         root;
    logic                    box_ok;
    logic [8:0]              top;
    logic [79:0]             out_data;

    function automatic logic signed [11:0] round_fix(input logic signed [RV_W-1:0] v);
        logic signed [RV_W-1:0] mag;
        logic signed [RV_W-1:0] r;
        mag = v[RV_W-1] ? -v : v;
        r = (mag + RV_W'(1 << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
        return v[RV_W-1] ? -r[11:0] : r[11:0];
    endfunction

    function automatic logic in_box(input logic signed [11:0] x1, input logic signed [11:0] y1,
                                    input logic signed [11:0] x2, input logic signed [11:0] y2,
                                    input logic signed [NUM_W-1:0] tx,
                                    input logic signed [NUM_W-1:0] ty);
        logic signed [NUM_W-1:0] lx, hx, ly, hy;
        lx = (x1 < x2) ? NUM_W'(x1) : NUM_W'(x2);
        hx = (x1 < x2) ? NUM_W'(x2) : NUM_W'(x1);
        ly = (y1 < y2) ? NUM_W'(y1) : NUM_W'(y2);
        hy = (y1 < y2) ? NUM_W'(y2) : NUM_W'(y1);
        return (lx <= tx) && (tx <= hx) && (ly <= ty) && (ty <= hy);
    endfunction

    assign px_s    = $signed({1'b0, cmd_reg.px});
    assign py_s    = $signed({1'b0, cmd_reg.py});
    assign rng_s   = $signed({1'b0, view_range_reg});
    assign n_walls = (wall_count_reg > WALL_CNT_W'(MAX_WALLS)) ? WALL_CNT_W'(MAX_WALLS)
                                                              : wall_count_reg;
    assign last_wall = (widx_reg + 1'b1 == n_walls);
    assign fifo_pop  = (state_reg == S_IDLE) && !fifo_empty;
    assign div_go    = (state_reg == S_DIVGO);
    assign sq_go     = (state_reg == S_SQGO);
    assign load_out  = (state_reg == S_FIN) && (!m_valid_reg || m_tready);
    assign box_ok    = in_box(12'(px_s), 12'(py_s), tx_reg, ty_reg, qx, qy) &&
                       in_box(ax_reg, ay_reg, ex_reg, ey_reg, qx, qy);
    assign top       = best_reg[9:1];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    rsch_div u_divx (
        .aclk(aclk), .aresetn(aresetn), .start(div_go),
        .num(numx_reg), .den(det_reg), .busy(divx_busy), .quo(qx)
    );
    rsch_div u_divy (
        .aclk(aclk), .aresetn(aresetn), .start(div_go),
        .num(numy_reg), .den(det_reg), .busy(divy_busy), .quo(qy)
    );
    rsch_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_go),
        .rad(sq_reg), .busy(sq_busy), .root(root)
    );

    always_comb begin
        prodx_next = (RV_W - 1)'(rng_s * cmd_reg.cs);
        prody_next = (RV_W - 1)'(rng_s * cmd_reg.sn);
        tx_next = round_fix(RV_W'({1'b0, cmd_reg.px, TRIG_FRAC_BITS'(0)}) + RV_W'(prodx_reg));
        ty_next = round_fix(RV_W'({1'b0, cmd_reg.py, TRIG_FRAC_BITS'(0)}) + RV_W'(prody_reg));
        a1_next = 13'(ty_next) - 13'(py_s);
        b1_next = 13'(px_s) - 13'(tx_next);
        c1_next = 23'(25'(a1_reg * px_s) + 25'(b1_reg * py_s));
        c2_next = 22'(24'(a2_reg * ax_reg) + 24'(b2_reg * ay_reg));
        det_next = DEN_W'(25'(a1_reg * b2_reg) - 25'(a2_reg * b1_reg));
        numx_next = NUM_W'(37'(b2_reg * c1_reg) - 37'(b1_reg * c2_reg));
        numy_next = NUM_W'(37'(a1_reg * c2_reg) - 37'(a2_reg * c1_reg));
        sq_next = SQ_W'(25'(dx_reg * dx_reg) + 25'(dy_reg * dy_reg));
    end

    always_comb begin
        state_next = state_reg;
        widx_next  = widx_reg;
        case (state_reg)
            S_IDLE: begin
                if (!fifo_empty && fifo_dout.mode == MODE_CAST) begin
                    state_next = S_END;
                end
            end
            S_END:   state_next = S_RAY;
            S_RAY:   state_next = S_C1;
            S_C1: begin
                widx_next  = '0;
                state_next = (n_walls == '0) ? S_FIN : S_FETCH;
            end
            S_FETCH: state_next = S_PREP;
            S_PREP:  state_next = S_C2;
            S_C2:    state_next = S_DET;
            S_DET: begin
                if (det_next == '0) begin
                    widx_next  = widx_reg + 1'b1;
                    state_next = last_wall ? S_FIN : S_FETCH;
                end else begin
                    state_next = S_NUMX;
                end
            end
            S_NUMX:  state_next = S_NUMY;
            S_NUMY:  state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIVW;
            S_DIVW: begin
                if (!divx_busy && !divy_busy) begin
                    state_next = S_BOX;
                end
            end
            S_BOX: begin
                if (box_ok) begin
                    state_next = S_SQ;
                end else begin
                    widx_next  = widx_reg + 1'b1;
                    state_next = last_wall ? S_FIN : S_FETCH;
                end
            end
            S_SQ:    state_next = S_SQGO;
            S_SQGO:  state_next = S_SQW;
            S_SQW: begin
                if (!sq_busy) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                widx_next  = widx_reg + 1'b1;
                state_next = last_wall ? S_FIN : S_FETCH;
            end
            S_FIN: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_data = '0;
        out_data[9:0]   = bx_reg;
        out_data[19:10] = by_reg;
        out_data[29:20] = best_reg;
        out_data[44:30] = 15'(16'(bar_width_reg * (7'(cmd_reg.column) + 7'd1)) +
                              16'(bar_origin_reg));
        out_data[53:45] = top;
        out_data[65:54] = 12'(screen_height_reg) - 12'({top, 1'b0});
        out_data[73:66] = top[8] ? 8'd0 : ~top[7:0];
        out_data[79:74] = cmd_reg.column;
    end

    always_ff @(posedge aclk) begin
        if (fifo_pop && fifo_dout.mode == MODE_LOAD) begin
            wall_mem[fifo_dout.wall_index] <= fifo_dout.wall;
        end
        rd_reg <= wall_mem[widx_reg[WALL_IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            wall_count_reg    <= '0;
            view_range_reg    <= 10'd300;
            screen_height_reg <= 11'd480;
            bar_width_reg     <= 8'd7;
            bar_origin_reg    <= 11'd213;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WALL_COUNT:    wall_count_reg    <= cfg_data[WALL_CNT_W-1:0];
                    CFG_VIEW_RANGE:    view_range_reg    <= cfg_data[9:0];
                    CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                    CFG_BAR_WIDTH:     bar_width_reg     <= cfg_data[7:0];
                    CFG_BAR_ORIGIN:    bar_origin_reg    <= cfg_data;
                    default:           ;
                endcase
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        widx_reg <= widx_next;
        if (fifo_pop) begin
            cmd_reg <= fifo_dout;
        end
        if (load_out) begin
            m_data_reg <= out_data;
            m_user_reg <= hit_reg;
        end
        case (state_reg)
            S_END: begin
                prodx_reg <= prodx_next;
                prody_reg <= prody_next;
            end
            S_RAY: begin
                tx_reg <= tx_next;
                ty_reg <= ty_next;
                a1_reg <= a1_next;
                b1_reg <= b1_next;
            end
            S_C1: begin
                c1_reg   <= c1_next;
                best_reg <= view_range_reg;
                bx_reg   <= '0;
                by_reg   <= '0;
                hit_reg  <= 1'b0;
            end
            S_PREP: begin
                ax_reg <= $signed({2'b0, rd_reg[9:0]});
                ay_reg <= $signed({2'b0, rd_reg[19:10]});
                ex_reg <= $signed({2'b0, rd_reg[29:20]});
                ey_reg <= $signed({2'b0, rd_reg[39:30]});
                a2_reg <= $signed({1'b0, rd_reg[39:30]}) - $signed({1'b0, rd_reg[19:10]});
                b2_reg <= $signed({1'b0, rd_reg[9:0]}) - $signed({1'b0, rd_reg[29:20]});
            end
            S_C2:   c2_reg   <= c2_next;
            S_DET:  det_reg  <= det_next;
            S_NUMX: numx_reg <= numx_next;
            S_NUMY: numy_reg <= numy_next;
            S_BOX: begin
                dx_reg <= 12'(qx) - 12'(px_s);
                dy_reg <= 12'(qy) - 12'(py_s);
            end
            S_SQ: sq_reg <= sq_next;
            S_CMP: begin
                if ({1'b0, root} < {1'b0, best_reg}) begin
                    best_reg <= root[9:0];
                    bx_reg   <= qx[9:0];
                    by_reg   <= qy[9:0];
                    hit_reg  <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIVGO) |-> (!divx_busy && !divy_busy))
        else $error("divider restarted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQGO) |=> sq_busy)
        else $error("square root did not start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the finish step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |-> (widx_reg < n_walls))
        else $error("wall index beyond walls in use");
endmodule
